/* src/trc_pkg.sv */
// Shared types and constants for the tile LRU cache.
// Used by trc_cell, tile_lru_cache and the testbench; depends on nothing else.
package trc_pkg;

    localparam int DEFAULT_MAX_SLOTS = 128;
    localparam int CFG_W             = 8;
    localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;
    localparam int STAMP_W           = 64;
    localparam int PAYLOAD_W         = 16;
    localparam int SLOT_INDEX_W      = 7;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_STORE  = 1'b1;

    localparam logic REG_SLOTS_IN_USE = 1'b0;

    typedef struct packed {
        logic [4:0]  zoom;
        logic [31:0] col;
        logic [31:0] row;
    } tile_key_t;

    // Search word handed from cell to cell.
    typedef struct packed {
        logic                 valid;
        logic                 op;
        logic                 meshable;
        tile_key_t            key;
        logic [PAYLOAD_W-1:0] handle;
        logic                 hit;
        logic [PAYLOAD_W-1:0] hit_payload;
        logic                 free_found;
        logic                 min_found;
        logic [STAMP_W-1:0]   min_stamp;
    } probe_t;

    // Slot write broadcast from the top level.
    typedef struct packed {
        logic                 en;
        tile_key_t            key;
        logic [PAYLOAD_W-1:0] payload;
        logic [STAMP_W-1:0]   stamp;
    } slot_wr_t;

endpackage

/* src/trc_cell.sv */
// One cache slot of the tile LRU cache chain.
// Depends on trc_pkg.
module trc_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 7,
    parameter int CNT_W = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [CNT_W-1:0]             n_active,
    input  logic [trc_pkg::STAMP_W-1:0]  stamp_new,
    input  trc_pkg::slot_wr_t            wr,
    input  logic [IDX_W-1:0]             wr_idx,
    input  trc_pkg::probe_t              probe_in,
    input  logic [IDX_W-1:0]             hit_idx_in,
    input  logic [IDX_W-1:0]             free_idx_in,
    input  logic [IDX_W-1:0]             min_idx_in,
    output trc_pkg::probe_t              probe_out,
    output logic [IDX_W-1:0]             hit_idx_out,
    output logic [IDX_W-1:0]             free_idx_out,
    output logic [IDX_W-1:0]             min_idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

    logic                          valid_reg;
    trc_pkg::tile_key_t            key_reg;
    logic [trc_pkg::PAYLOAD_W-1:0] payload_reg;
    logic [trc_pkg::STAMP_W-1:0]   stamp_reg;

    trc_pkg::probe_t  probe_reg, probe_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [IDX_W-1:0] min_idx_reg, min_idx_next;

    logic active;
    logic take_hit;

    assign active   = probe_in.valid && (MY_CNT < n_active);
    assign take_hit = active && (probe_in.op == trc_pkg::OP_LOOKUP) && !probe_in.hit
                      && valid_reg && (key_reg == probe_in.key);

    always_comb begin
        probe_next    = probe_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        min_idx_next  = min_idx_in;
        if (take_hit) begin
            probe_next.hit         = 1'b1;
            probe_next.hit_payload = payload_reg;
            hit_idx_next           = MY_IDX;
        end
        if (active && (probe_in.op == trc_pkg::OP_STORE)) begin
            if (!valid_reg) begin
                if (!probe_in.free_found) begin
                    probe_next.free_found = 1'b1;
                    free_idx_next         = MY_IDX;
                end
            end else if (!probe_in.min_found || (stamp_reg < probe_in.min_stamp)) begin
                probe_next.min_found = 1'b1;
                probe_next.min_stamp = stamp_reg;
                min_idx_next         = MY_IDX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            probe_reg.valid <= 1'b0;
        end else begin
            probe_reg.valid <= probe_next.valid;
            if (wr.en && (wr_idx == MY_IDX)) begin
                valid_reg <= 1'b1;
            end
            probe_reg.op          <= probe_next.op;
            probe_reg.meshable    <= probe_next.meshable;
            probe_reg.key         <= probe_next.key;
            probe_reg.handle      <= probe_next.handle;
            probe_reg.hit         <= probe_next.hit;
            probe_reg.hit_payload <= probe_next.hit_payload;
            probe_reg.free_found  <= probe_next.free_found;
            probe_reg.min_found   <= probe_next.min_found;
            probe_reg.min_stamp   <= probe_next.min_stamp;
            hit_idx_reg           <= hit_idx_next;
            free_idx_reg          <= free_idx_next;
            min_idx_reg           <= min_idx_next;
            if (wr.en && (wr_idx == MY_IDX)) begin
                key_reg     <= wr.key;
                payload_reg <= wr.payload;
                stamp_reg   <= wr.stamp;
            end else if (take_hit) begin
                stamp_reg <= stamp_new;
            end
        end
    end

    assign probe_out    = probe_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;
    assign min_idx_out  = min_idx_reg;

endmodule

/* src/tile_lru_cache.sv */
// Top level of the tile LRU cache: stream ports, APB register, use counter
// and the chain of slot cells. Depends on trc_pkg and trc_cell.
//
//  channel | direction | contents
//  s_*     | in        | tuser: operation; tdata: zoom, col, row, handle, meshable
//  m_*     | out       | tdata: hit, stored, slot_index, payload_out
//  APB     | in        | register 0 at byte address 0: slots_in_use
//
// The search word steps through one slot cell per cycle, then the result is
// committed and written out.
// One item is in the chain at a time; the next is taken once the previous
// commits, even while its result still waits in the output register.
// Reset is synchronous; it clears all slot valid bits and the use counter.
module tile_lru_cache #(
    parameter int MAX_SLOTS = trc_pkg::DEFAULT_MAX_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // zoom[4:0], col[36:5], row[68:37], handle[84:69],
                                   // meshable[85], zero[87:86]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // hit[0], stored[1], slot_index[8:2], payload_out[24:9],
                                   // zero[31:25]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    logic [trc_pkg::CFG_W-1:0]   cfg_reg;
    logic [CNT_W-1:0]            n_active;
    logic [trc_pkg::STAMP_W-1:0] use_cnt_reg;
    logic [trc_pkg::STAMP_W-1:0] stamp_new;
    logic                        busy_reg;

    trc_pkg::probe_t  probe    [MAX_SLOTS+1];
    logic [IDX_W-1:0] hit_idx  [MAX_SLOTS+1];
    logic [IDX_W-1:0] free_idx [MAX_SLOTS+1];
    logic [IDX_W-1:0] min_idx  [MAX_SLOTS+1];

    trc_pkg::probe_t  done_reg;
    logic [IDX_W-1:0] done_hit_idx_reg, done_vic_idx_reg;
    logic             commit;
    logic             do_store;
    logic             do_hit;
    logic [IDX_W-1:0] res_idx;
    logic [IDX_W+6:0] res_idx_wide;
    trc_pkg::slot_wr_t wr;
    logic             s_xfer;
    logic [31:0]      m_tdata_reg;
    logic             m_tvalid_reg;

    // APB register.
    assign pready = 1'b1;
    assign prdata = {24'd0, cfg_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= trc_pkg::CFG_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == trc_pkg::REG_SLOTS_IN_USE)) begin
            cfg_reg <= pwdata[trc_pkg::CFG_W-1:0];
        end
    end

    // Zero or an oversized count means every slot.
    always_comb begin
        if ((cfg_reg == '0) || ({24'd0, cfg_reg} > 32'(MAX_SLOTS))) begin
            n_active = CNT_W'(MAX_SLOTS);
        end else begin
            n_active = CNT_W'(cfg_reg);
        end
    end

    assign stamp_new = use_cnt_reg + 64'd1;
    assign s_tready  = !busy_reg;
    assign s_xfer    = s_tvalid && s_tready;

    always_comb begin
        probe[0]             = '0;
        probe[0].valid       = s_xfer;
        probe[0].op          = s_tuser;
        probe[0].key.zoom    = s_tdata[4:0];
        probe[0].key.col     = s_tdata[36:5];
        probe[0].key.row     = s_tdata[68:37];
        probe[0].handle      = s_tdata[84:69];
        probe[0].meshable    = s_tdata[85];
        hit_idx[0]           = '0;
        free_idx[0]          = '0;
        min_idx[0]           = '0;
    end

    for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
        trc_cell #(
            .IDX   (i),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .n_active     (n_active),
            .stamp_new    (stamp_new),
            .wr           (wr),
            .wr_idx       (done_vic_idx_reg),
            .probe_in     (probe[i]),
            .hit_idx_in   (hit_idx[i]),
            .free_idx_in  (free_idx[i]),
            .min_idx_in   (min_idx[i]),
            .probe_out    (probe[i+1]),
            .hit_idx_out  (hit_idx[i+1]),
            .free_idx_out (free_idx[i+1]),
            .min_idx_out  (min_idx[i+1])
        );
    end

    // The finished search word waits here until the output register is free.
    assign commit   = done_reg.valid && (!m_tvalid_reg || m_tready);
    assign do_store = (done_reg.op == trc_pkg::OP_STORE) && done_reg.meshable;
    assign do_hit   = (done_reg.op == trc_pkg::OP_LOOKUP) && done_reg.hit;

    always_comb begin
        wr.en      = commit && do_store;
        wr.key     = done_reg.key;
        wr.payload = done_reg.handle;
        wr.stamp   = stamp_new;
    end

    always_comb begin
        if (do_store) begin
            res_idx = done_vic_idx_reg;
        end else if (do_hit) begin
            res_idx = done_hit_idx_reg;
        end else begin
            res_idx = '0;
        end
    end
    assign res_idx_wide = {7'd0, res_idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            done_reg.valid <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            use_cnt_reg    <= '0;
        end else begin
            if (s_xfer) begin
                busy_reg <= 1'b1;
            end else if (commit) begin
                busy_reg <= 1'b0;
            end
            if (probe[MAX_SLOTS].valid) begin
                done_reg.valid <= 1'b1;
            end else if (commit) begin
                done_reg.valid <= 1'b0;
            end
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (commit && (do_store || do_hit)) begin
                use_cnt_reg <= stamp_new;
            end
            if (probe[MAX_SLOTS].valid) begin
                done_reg.op          <= probe[MAX_SLOTS].op;
                done_reg.meshable    <= probe[MAX_SLOTS].meshable;
                done_reg.key         <= probe[MAX_SLOTS].key;
                done_reg.handle      <= probe[MAX_SLOTS].handle;
                done_reg.hit         <= probe[MAX_SLOTS].hit;
                done_reg.hit_payload <= probe[MAX_SLOTS].hit_payload;
                done_reg.free_found  <= probe[MAX_SLOTS].free_found;
                done_reg.min_found   <= probe[MAX_SLOTS].min_found;
                done_reg.min_stamp   <= probe[MAX_SLOTS].min_stamp;
                done_hit_idx_reg     <= hit_idx[MAX_SLOTS];
                done_vic_idx_reg     <= probe[MAX_SLOTS].free_found ? free_idx[MAX_SLOTS]
                                                                    : min_idx[MAX_SLOTS];
            end
            if (commit) begin
                m_tdata_reg <= {7'd0,
                                do_hit ? done_reg.hit_payload : 16'd0,
                                res_idx_wide[6:0],
                                do_store,
                                do_hit};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* verif/tb_tile_lru_cache.sv */
`timescale 1ns / 100ps
// Self-checking testbench for tile_lru_cache: directed table, then random phases
// over several slot counts, checked against an in-bench LRU predictor. Uses trc_pkg.
module tb_tile_lru_cache;

    localparam int NSLOTS = trc_pkg::DEFAULT_MAX_SLOTS;
    localparam logic OP_LOOKUP = trc_pkg::OP_LOOKUP;
    localparam logic OP_STORE  = trc_pkg::OP_STORE;
    localparam logic [2:0] ADDR_SLOTS_IN_USE = {trc_pkg::REG_SLOTS_IN_USE, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 2 * NSLOTS + 10;
    localparam int POOL_N = 12;

    typedef struct packed {
        logic                             hit;
        logic                             stored;
        logic [trc_pkg::SLOT_INDEX_W-1:0] slot;
        logic [trc_pkg::PAYLOAD_W-1:0]    payload;
    } cache_result_t;

    typedef struct packed {
        logic                          op;
        trc_pkg::tile_key_t            key;
        logic [trc_pkg::PAYLOAD_W-1:0] handle;
        logic                          meshable;
        logic                          typed;
        cache_result_t                 res;
    } tile_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;  // zoom, col, row, handle, meshable, zero pad
    logic        s_tuser = 1'b0; // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;       // hit, stored, slot_index, payload_out, zero pad
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tile_lru_cache u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state.
    logic                          mdl_valid   [NSLOTS];
    trc_pkg::tile_key_t            mdl_key     [NSLOTS];
    logic [trc_pkg::PAYLOAD_W-1:0] mdl_payload [NSLOTS];
    logic [trc_pkg::STAMP_W-1:0]   mdl_stamp   [NSLOTS];
    logic [trc_pkg::STAMP_W-1:0]   mdl_use_count;
    logic [trc_pkg::CFG_W-1:0]     mdl_slots_cfg;

    cache_result_t      expected_results[$];
    trc_pkg::tile_key_t key_pool[POOL_N];
    int                 error_count = 0;
    int                 cycle_count = 0;
    bit                 long_hold_req = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int active_slot_count();
        if (mdl_slots_cfg == 0 || mdl_slots_cfg > NSLOTS)
            return NSLOTS;
        return int'(mdl_slots_cfg);
    endfunction

    // Applies one request to the predictor state and returns its result.
    function automatic cache_result_t cache_predict(tile_req_t req);
        cache_result_t r;
        int n;
        int victim;
        bit free_found;
        r = '0;
        n = active_slot_count();
        victim = 0;
        free_found = 1'b0;
        if (req.op == OP_LOOKUP) begin
            for (int i = 0; i < n; i++) begin
                if (mdl_valid[i] && mdl_key[i] == req.key) begin
                    mdl_use_count = mdl_use_count + 1;
                    mdl_stamp[i] = mdl_use_count;
                    r.hit = 1'b1;
                    r.slot = i[trc_pkg::SLOT_INDEX_W-1:0];
                    r.payload = mdl_payload[i];
                    break;
                end
            end
            return r;
        end
        if (!req.meshable)
            return r;
        for (int i = 0; i < n; i++) begin
            if (!mdl_valid[i]) begin
                victim = i;
                free_found = 1'b1;
                break;
            end
        end
        if (!free_found) begin
            for (int i = 1; i < n; i++)
                if (mdl_stamp[i] < mdl_stamp[victim])
                    victim = i;
        end
        mdl_valid[victim] = 1'b1;
        mdl_key[victim] = req.key;
        mdl_payload[victim] = req.handle;
        mdl_use_count = mdl_use_count + 1;
        mdl_stamp[victim] = mdl_use_count;
        r.stored = 1'b1;
        r.slot = victim[trc_pkg::SLOT_INDEX_W-1:0];
        return r;
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SLOTS_IN_USE)
            mdl_slots_cfg = data[trc_pkg::CFG_W-1:0];
    endtask

    // Offers one request, waits for the transfer, then records what must come back.
    task automatic send_tile_req(input tile_req_t req, input bit allow_gap);
        cache_result_t predicted;
        int gap;
        int pick;
        s_tvalid <= 1'b1;
        s_tuser <= req.op;
        s_tdata <= {2'b00, req.meshable, req.handle, req.key.row, req.key.col, req.key.zoom};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = cache_predict(req);
        expected_results.push_back(req.typed ? req.res : predicted);
        gap = 0;
        if (allow_gap) begin
            pick = $urandom_range(0, 9);
            if (pick >= 9)
                gap = $urandom_range(20, 150);
            else if (pick >= 6)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        while (expected_results.size() != 0) @(posedge aclk);
        // Gives the bench a margin after the last result has been taken.
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic tile_req_t random_tile_req();
        tile_req_t req;
        req = '0;
        req.op = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0) begin
            req.key = key_pool[$urandom_range(0, POOL_N - 1)];
        end else begin
            req.key.zoom = 5'($urandom_range(0, 31));
            req.key.col = $urandom;
            req.key.row = $urandom;
        end
        req.handle = 16'($urandom);
        req.meshable = ($urandom_range(0, 7) != 0);
        return req;
    endfunction

    // Receiver: short and occasional longer random stalls, stall-free stretches, and one long hold-off.
    initial begin
        int gap;
        forever begin
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (1000) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                  : $urandom_range(1, 3);
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        cache_result_t got;
        cache_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit = m_tdata[0];
            got.stored = m_tdata[1];
            got.slot = m_tdata[8:2];
            got.payload = m_tdata[24:9];
            if (expected_results.size() == 0) begin
                $display("%0t: result transfer with none expected: %h", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.hit !== want.hit) begin
                    $display("%0t: hit expected %b got %b", $time, want.hit, got.hit);
                    error_count++;
                end
                if (got.stored !== want.stored) begin
                    $display("%0t: stored expected %b got %b", $time, want.stored, got.stored);
                    error_count++;
                end
                if (got.slot !== want.slot) begin
                    $display("%0t: slot_index expected %0d got %0d", $time, want.slot, got.slot);
                    error_count++;
                end
                if (got.payload !== want.payload) begin
                    $display("%0t: payload_out expected %h got %h", $time,
                             want.payload, got.payload);
                    error_count++;
                end
            end
        end
    end

    initial begin
        // op, {zoom, col, row}, handle, meshable, typed, {hit, stored, slot, payload}
        tile_req_t directed[14] = '{
            '{OP_LOOKUP, '{5'd0, 32'h0, 32'h0}, 16'h0, 1'b1, 1'b1, '{1'b0, 1'b0, 7'd0, 16'h0}},
            '{OP_STORE, '{5'd31, '1, '1}, 16'hFFFF, 1'b0, 1'b1, '{1'b0, 1'b0, 7'd0, 16'h0}},
            '{OP_LOOKUP, '{5'd31, '1, '1}, 16'h0, 1'b0, 1'b1, '{1'b0, 1'b0, 7'd0, 16'h0}},
            '{OP_STORE, '{5'd31, '1, '1}, 16'hFFFF, 1'b1, 1'b1, '{1'b0, 1'b1, 7'd0, 16'h0}},
            '{OP_LOOKUP, '{5'd31, '1, '1}, 16'h1234, 1'b0, 1'b1,
              '{1'b1, 1'b0, 7'd0, 16'hFFFF}},
            '{OP_STORE, '{5'd0, 32'h0, 32'h0}, 16'h0, 1'b1, 1'b1, '{1'b0, 1'b1, 7'd1, 16'h0}},
            '{OP_LOOKUP, '{5'd0, 32'h0, 32'h0}, 16'h0, 1'b1, 1'b1, '{1'b1, 1'b0, 7'd1, 16'h0}},
            '{OP_STORE, '{5'd0, 32'h0, 32'h0}, 16'h5555, 1'b1, 1'b1,
              '{1'b0, 1'b1, 7'd2, 16'h0}},
            '{OP_LOOKUP, '{5'd0, 32'h0, 32'h0}, 16'h0, 1'b0, 1'b1, '{1'b1, 1'b0, 7'd1, 16'h0}},
            '{OP_LOOKUP, '{5'd31, 32'h0, 32'h0}, 16'h0, 1'b1, 1'b1, '{1'b0, 1'b0, 7'd0, 16'h0}},
            '{OP_LOOKUP, '{5'd0, '1, 32'h0}, 16'h0, 1'b1, 1'b1, '{1'b0, 1'b0, 7'd0, 16'h0}},
            '{OP_STORE, '{5'd5, 32'hAAAA5555, 32'h5555AAAA}, 16'hAAAA, 1'b1, 1'b1,
              '{1'b0, 1'b1, 7'd3, 16'h0}},
            '{OP_LOOKUP, '{5'd5, 32'hAAAA5555, 32'h5555AAAA}, 16'h0, 1'b1, 1'b1,
              '{1'b1, 1'b0, 7'd3, 16'hAAAA}},
            '{OP_LOOKUP, '{5'd5, 32'hAAAA5555, 32'h5555AAAB}, 16'h0, 1'b1, 1'b1,
              '{1'b0, 1'b0, 7'd0, 16'h0}}
        };
        // Slot counts per phase: zero and oversize values mean all slots.
        logic [31:0] phase_slots[10] = '{32'd4, 32'd1, 32'd0, 32'd3, 32'd200,
                                         32'd16, 32'h1FF, 32'd8, 32'd128, 32'd2};
        for (int i = 0; i < NSLOTS; i++)
            mdl_valid[i] = 1'b0;
        mdl_use_count = '0;
        mdl_slots_cfg = trc_pkg::CFG_RESET;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_tile_req(directed[i], i[0]);
        s_tvalid <= 1'b0;
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            apb_write(ADDR_SLOTS_IN_USE, phase_slots[ph]);
            if (ph == 3)
                apb_write(ADDR_UNMAPPED, 32'd7);
            for (int k = 0; k < POOL_N; k++) begin
                key_pool[k].zoom = 5'($urandom_range(0, 31));
                key_pool[k].col = $urandom;
                key_pool[k].row = $urandom;
            end
            for (int n = 0; n < 150; n++) begin
                if (ph == 2 && n == 40)
                    long_hold_req = 1'b1;
                send_tile_req(random_tile_req(), ph != 5);
            end
            s_tvalid <= 1'b0;
            wait_idle();
        end

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
src/trc_pkg.sv
src/trc_cell.sv
src/tile_lru_cache.sv
verif/tb_tile_lru_cache.sv
